[src/assert_macros.svh]
// Assertion macros shared by the checker files.
// Include guarded; holds only macro definitions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset.
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[src/rv64_pkg.sv]
// Types and constants for the RV64I core.
// No dependencies.
`timescale 1ns / 1ps
package rv64_pkg;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_IMM32  = 7'h1b;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_REG32  = 7'h3b;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_JAL    = 7'h6f;
    localparam logic [31:0] UPPER_MASK = 32'hfffff000;

    localparam logic [1:0] ST_COMMIT  = 2'd0;
    localparam logic [1:0] ST_LOADREQ = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic KIND_INSN = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    // Item handed from front to back.
    typedef struct packed {
        logic        kind;
        logic [31:0] insn;
        logic [63:0] data;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [63:0] commit_pc;
        logic [31:0] commit_insn;
        logic [1:0]  status;
        logic        reg_we;
        logic [4:0]  reg_idx;
        logic [63:0] reg_val;
        logic        store_valid;
        logic [63:0] mem_addr;
        logic [3:0]  mem_size;
        logic [63:0] store_data;
        logic [63:0] next_pc;
    } t_result;
endpackage

[src/rv64_front.sv]
// Front end: accepts input items and holds them in a two-entry queue.
// Depends on rv64_pkg.
`timescale 1ns / 1ps
module rv64_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rv64_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output rv64_pkg::t_item o_item
);
    rv64_pkg::t_item r_q [2];
    logic            r_rd, r_wr;
    logic [1:0]      r_cnt;
    logic            push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_q[r_rd];

    // Advance pointers and count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    // Store entries.
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_item;
    end
endmodule

[src/rv64_back.sv]
// Back end: executes queued items against the register file and pc.
// Depends on rv64_pkg.
`timescale 1ns / 1ps
module rv64_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rv64_pkg::t_item     i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output rv64_pkg::t_result   o_res
);
    logic [63:0] r_rf [32];
    logic [31:0] r_rf_ok;
    logic [63:0] r_pc;
    logic        r_lp;
    logic [4:0]  r_pd;
    logic [2:0]  r_pk;
    logic [63:0] r_ppc;
    logic [31:0] r_pins;
    logic        r_ov;
    rv64_pkg::t_result r_res;

    rv64_pkg::t_result n_res;
    logic        fire;
    logic [63:0] pc, a, b, immi, v, np, sum, d, ldv;
    logic [31:0] w, a32, b32, t32;
    logic [6:0]  op;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6, sh;
    logic        ok, wrd, tk, lts_ab, ltu_ab;
    logic        n_lp_set, n_lp_clr, n_commit;

    assign o_ready = !r_ov || i_ready;
    assign fire    = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign pc      = r_pc;

    // Decode and execute one item.
    always_comb begin
        w    = i_item.insn;
        op   = w[6:0];
        rd   = w[11:7];
        f3   = w[14:12];
        rs1  = w[19:15];
        rs2  = w[24:20];
        f7   = w[31:25];
        f6   = w[31:26];
        a    = r_rf_ok[rs1] ? r_rf[rs1] : 64'd0;
        b    = r_rf_ok[rs2] ? r_rf[rs2] : 64'd0;
        a32  = a[31:0];
        b32  = b[31:0];
        immi = {{52{w[31]}}, w[31:20]};
        np   = pc + 64'd4;
        v    = 64'd0;
        t32  = 32'd0;
        sh   = 6'd0;
        ok   = 1'b1;
        wrd  = 1'b1;
        tk   = 1'b0;
        sum  = 64'd0;
        d    = i_item.data;
        ldv  = d;
        lts_ab = $signed(a) < $signed(b);
        ltu_ab = a < b;
        n_lp_set = 1'b0;
        n_lp_clr = 1'b0;
        n_commit = 1'b0;
        n_res = '0;
        if (i_item.kind == rv64_pkg::KIND_DATA) begin
            if (!r_lp) begin
                n_res.commit_pc = pc;
                n_res.status    = rv64_pkg::ST_IGNORED;
                n_res.next_pc   = pc;
            end else begin
                case (r_pk)
                    3'd0: ldv = {{56{d[7]}}, d[7:0]};
                    3'd1: ldv = {{48{d[15]}}, d[15:0]};
                    3'd2: ldv = {{32{d[31]}}, d[31:0]};
                    3'd4: ldv = {56'd0, d[7:0]};
                    3'd5: ldv = {48'd0, d[15:0]};
                    3'd6: ldv = {32'd0, d[31:0]};
                    default: ldv = d;
                endcase
                n_lp_clr = 1'b1;
                n_res.commit_pc   = r_ppc;
                n_res.commit_insn = r_pins;
                n_res.status      = rv64_pkg::ST_COMMIT;
                n_res.reg_we      = (r_pd != 5'd0);
                n_res.reg_idx     = (r_pd != 5'd0) ? r_pd : 5'd0;
                n_res.reg_val     = (r_pd != 5'd0) ? ldv : 64'd0;
                n_res.next_pc     = pc;
            end
        end else begin
            n_res.commit_pc   = pc;
            n_res.commit_insn = w;
            case (op)
                rv64_pkg::OP_LUI:   v = {{32{w[31]}}, w & rv64_pkg::UPPER_MASK};
                rv64_pkg::OP_AUIPC: v = pc + {32'd0, w & rv64_pkg::UPPER_MASK};
                rv64_pkg::OP_IMM: begin
                    sh = w[25:20];
                    case (f3)
                        3'd0: v = a + immi;
                        3'd2: v = {63'd0, $signed(a) < $signed(immi)};
                        3'd3: v = {63'd0, a < immi};
                        3'd4: v = a ^ immi;
                        3'd6: v = a | immi;
                        3'd7: v = a & immi;
                        3'd1: if (f6 != 6'd0) ok = 1'b0; else v = a << sh;
                        default: begin
                            if (f6 == 6'd0) v = a >> sh;
                            else if (f6 == 6'h10) v = $unsigned($signed(a) >>> sh);
                            else ok = 1'b0;
                        end
                    endcase
                end
                rv64_pkg::OP_IMM32, rv64_pkg::OP_REG32: begin
                    sh = {1'b0, (op == rv64_pkg::OP_IMM32) ? w[24:20] : b[4:0]};
                    if (f3 == 3'd0 && op == rv64_pkg::OP_IMM32) t32 = a32 + immi[31:0];
                    else if (f3 == 3'd0 && f7 == 7'd0) t32 = a32 + b32;
                    else if (f3 == 3'd0 && f7 == 7'h20) t32 = a32 - b32;
                    else if (f3 == 3'd1 && f7 == 7'd0) t32 = a32 << sh[4:0];
                    else if (f3 == 3'd5 && f7 == 7'd0) t32 = a32 >> sh[4:0];
                    else if (f3 == 3'd5 && f7 == 7'h20)
                        t32 = $unsigned($signed(a32) >>> sh[4:0]);
                    else ok = 1'b0;
                    v = {{32{t32[31]}}, t32};
                end
                rv64_pkg::OP_REG: begin
                    sh = b[5:0];
                    if (f7 == 7'd0) begin
                        case (f3)
                            3'd0: v = a + b;
                            3'd1: v = a << sh;
                            3'd2: v = {63'd0, lts_ab};
                            3'd3: v = {63'd0, ltu_ab};
                            3'd4: v = a ^ b;
                            3'd5: v = a >> sh;
                            3'd6: v = a | b;
                            default: v = a & b;
                        endcase
                    end else if (f7 == 7'h20 && f3 == 3'd0) v = a - b;
                    else if (f7 == 7'h20 && f3 == 3'd5) v = $unsigned($signed(a) >>> sh);
                    else ok = 1'b0;
                end
                rv64_pkg::OP_LOAD: begin
                    if (f3 == 3'd7) ok = 1'b0;
                    else begin
                        n_lp_set = 1'b1;
                        wrd = 1'b0;
                        n_res.status   = rv64_pkg::ST_LOADREQ;
                        n_res.mem_addr = a + immi;
                        n_res.mem_size = 4'd1 << f3[1:0];
                    end
                end
                rv64_pkg::OP_STORE: begin
                    wrd = 1'b0;
                    if (f3[2]) ok = 1'b0;
                    else begin
                        n_res.store_valid = 1'b1;
                        n_res.mem_addr = a + {{52{w[31]}}, w[31:25], w[11:7]};
                        n_res.mem_size = 4'd1 << f3[1:0];
                        case (f3[1:0])
                            2'd0: n_res.store_data = {56'd0, b[7:0]};
                            2'd1: n_res.store_data = {48'd0, b[15:0]};
                            2'd2: n_res.store_data = {32'd0, b[31:0]};
                            default: n_res.store_data = b;
                        endcase
                    end
                end
                rv64_pkg::OP_BRANCH: begin
                    wrd = 1'b0;
                    case (f3)
                        3'd0: tk = (a == b);
                        3'd1: tk = (a != b);
                        3'd4: tk = lts_ab;
                        3'd5: tk = !lts_ab;
                        3'd6: tk = ltu_ab;
                        3'd7: tk = !ltu_ab;
                        default: ok = 1'b0;
                    endcase
                    if (tk) np = pc + {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
                end
                rv64_pkg::OP_JALR: begin
                    if (f3 != 3'd0) ok = 1'b0;
                    v   = pc + 64'd4;
                    sum = a + immi;
                    np  = {sum[63:1], 1'b0};
                end
                rv64_pkg::OP_JAL: begin
                    v  = pc + 64'd4;
                    np = pc + {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
                end
                default: ok = 1'b0;
            endcase
            n_res.next_pc = np;
            if (!ok) begin
                n_res.status      = rv64_pkg::ST_ILLEGAL;
                n_res.store_valid = 1'b0;
                n_res.mem_addr    = 64'd0;
                n_res.mem_size    = 4'd0;
                n_res.store_data  = 64'd0;
                n_res.next_pc     = pc;
                n_lp_set          = 1'b0;
            end else begin
                n_commit = 1'b1;
                n_lp_clr = !n_lp_set;
                if (wrd && rd != 5'd0) begin
                    n_res.reg_we  = 1'b1;
                    n_res.reg_idx = rd;
                    n_res.reg_val = v;
                end
            end
        end
    end

    // Update architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_ok <= '0;
            r_pc    <= 64'd0;
            r_lp    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= fire || (r_ov && !i_ready);
            if (fire) begin
                if (n_res.reg_we) r_rf_ok[n_res.reg_idx] <= 1'b1;
                if (n_commit) r_pc <= n_res.next_pc;
                if (n_lp_set) r_lp <= 1'b1;
                else if (n_lp_clr) r_lp <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= n_res;
            if (n_res.reg_we) r_rf[n_res.reg_idx] <= n_res.reg_val;
            if (n_lp_set) begin
                r_pd   <= rd;
                r_pk   <= f3;
                r_ppc  <= pc;
                r_pins <= w;
            end
        end
    end
endmodule

[src/rv64i_integer_core_step_core.sv]
// Top level of the RV64I core: APB register, front queue and back end.
// Depends on rv64_pkg, rv64_front, rv64_back.
`timescale 1ns / 1ps
// One item per cycle unless the output stalls: each instruction word or load data
// item is executed combinationally by the back end, behind a two-entry input queue
// and a registered result stage, so items stream back to back. An accepted item
// is held in a queue entry and its result then in the result register; the input
// stalls only once both queue entries are held behind a stalled result. Loads
// report a request and finish when a later load-data item arrives. The pc is
// zero after reset, the reset value of start_address (byte 0); writing the
// register afterwards only changes what reads back.
module rv64i_integer_core_step_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // instruction_word[31:0], load_data[95:32]
    input  logic         s_axis_tuser,   // item kind: 0 instruction word, 1 load data
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // commit_pc, commit_instruction, reg_write_valid, reg_index, reg_value,
    // store_valid, mem_address, mem_size, store_data, next_pc (low to high)
    output logic [367:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    logic [63:0]       r_start;
    rv64_pkg::t_item   in_item, q_item;
    rv64_pkg::t_result res;
    logic              q_valid, q_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? r_start : 64'd0;

    // Hold the start address register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_start <= 64'd0;
        else if (psel && penable && pwrite && paddr == 3'd0) r_start <= pwdata;
    end

    assign in_item.kind = s_axis_tuser;
    assign in_item.insn = s_axis_tdata[31:0];
    assign in_item.data = s_axis_tdata[95:32];

    rv64_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_item),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    rv64_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {5'd0, res.next_pc, res.store_data, res.mem_size,
                           res.mem_addr, res.store_valid, res.reg_val, res.reg_idx,
                           res.reg_we, res.commit_insn, res.commit_pc};
endmodule

[src/rv64_checker.sv]
// Port-level checks for the RV64I core, bound to the top level.
// Depends on assert_macros.svh and rv64_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rv64_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [367:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);
    logic        stall, ill, lreq, res_we, res_store, size_ok;
    logic [4:0]  res_idx;
    logic [63:0] res_pc, res_next;

    // Pick out the fields the checks look at.
    assign stall     = m_axis_tvalid && !m_axis_tready;
    assign ill       = m_axis_tvalid && m_axis_tuser == rv64_pkg::ST_ILLEGAL;
    assign lreq      = m_axis_tvalid && m_axis_tuser == rv64_pkg::ST_LOADREQ;
    assign res_pc    = m_axis_tdata[63:0];
    assign res_we    = m_axis_tdata[96];
    assign res_idx   = m_axis_tdata[101:97];
    assign res_store = m_axis_tdata[166];
    assign size_ok   = m_axis_tdata[234:231] != 4'd0;
    assign res_next  = m_axis_tdata[362:299];

    // Result held while stalled.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, stall, m_axis_tvalid && $stable(m_axis_tdata))
    // Illegal results change no register and no pc.
    `ASSERT_IMPL(a_ill, i_clk, i_rst_n, ill, !res_we && res_next == res_pc)
    // Write to x0 never reported.
    `ASSERT_IMPL(a_x0, i_clk, i_rst_n, m_axis_tvalid && res_we, res_idx != 5'd0)
    // Load request carries a nonzero size and no store.
    `ASSERT_IMPL(a_lreq, i_clk, i_rst_n, lreq, size_ok && !res_store)
endmodule

bind rv64i_integer_core_step_core rv64_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
